FILE: hdl/ctm_pkg.sv
`default_nettype none

package ctm_pkg;

  // Default sizes
  localparam int YEAR_SLOTS_DEF = 64;
  localparam int RULE_SLOTS_DEF = 4;
  localparam int MAX_RULE_SLOTS = 4;

  // Configuration port
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_MASK   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MINUTE_MASK   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOUR_MASK     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MDAY_MASK     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MONTH_MASK    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WDAY_MASK     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_YEAR_MASK     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPECIAL_RULES = 3'd7;

  // Day-of-month slot kinds
  localparam logic [1:0] DAY_KIND_EMPTY     = 2'd0;
  localparam logic [1:0] DAY_KIND_NTH_LAST  = 2'd1;
  localparam logic [1:0] DAY_KIND_NEAREST   = 2'd2;
  localparam logic [1:0] DAY_KIND_LAST_WEEK = 2'd3;

  // Weekday slot kinds
  localparam logic [1:0] WDAY_KIND_EMPTY = 2'd0;
  localparam logic [1:0] WDAY_KIND_LAST  = 2'd1;
  localparam logic [1:0] WDAY_KIND_NTH   = 2'd2;
  localparam logic [1:0] WDAY_KIND_NEVER = 2'd3;

  localparam logic [2:0] SUNDAY      = 3'd0;
  localparam logic [2:0] MONDAY      = 3'd1;
  localparam logic [2:0] FRIDAY      = 3'd5;
  localparam logic [2:0] SATURDAY    = 3'd6;
  localparam logic [2:0] WDAY_ALIAS7 = 3'd7;

  // Calendar: year_offset is 8 bits, so years run 1970..2225. Inside that
  // window the only century years without a leap day are 2100 and 2200.
  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [11:0] NOLEAP_CENT0 = 12'd2100;
  localparam logic [11:0] NOLEAP_CENT1 = 12'd2200;
  localparam logic [3:0]  FEBRUARY     = 4'd1;

  typedef struct packed {
    logic [4:0] mday;
    logic [2:0] wd;    // weekday, 7 folded to Sunday
    logic [4:0] dim;   // days in month
  } ctm_ctx_t;

  typedef struct packed {
    logic day_hit;
    logic wday_hit;
  } ctm_hit_t;

  function automatic logic is_leap(input logic [7:0] yoff);
    logic [11:0] year;
    year = EPOCH_YEAR + {4'd0, yoff};
    return (year[1:0] == 2'd0) && (year != NOLEAP_CENT0) && (year != NOLEAP_CENT1);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    case (month)
      4'd0:    n = 5'd31;
      4'd1:    n = 5'd28;
      4'd2:    n = 5'd31;
      4'd3:    n = 5'd30;
      4'd4:    n = 5'd31;
      4'd5:    n = 5'd30;
      4'd6:    n = 5'd31;
      4'd7:    n = 5'd31;
      4'd8:    n = 5'd30;
      4'd9:    n = 5'd31;
      4'd10:   n = 5'd30;
      4'd11:   n = 5'd31;
      default: n = 5'd31;
    endcase
    if (month == FEBRUARY && leap) begin
      n = 5'd29;
    end
    return n;
  endfunction

  // x mod 7 by folding: 8 == 1 (mod 7)
  function automatic logic [2:0] mod7(input logic [6:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = {1'b0, x[6:3]} + {2'b0, x[2:0]};
    s2 = {2'b0, s1[4:3]} + {1'b0, s1[2:0]};
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

  // weekday of day d, given weekday wd on day mday
  function automatic logic [2:0] weekday_of(input logic [2:0] wd, input logic [4:0] mday,
                                            input logic [4:0] d);
    return mod7(7'(wd) + 7'(d) + 7'd35 - 7'(mday));
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ctm_stream_if.sv
`default_nettype none

interface ctm_time_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [4:0] day_of_month;
  logic [3:0] month;
  logic [2:0] weekday;
  logic [7:0] year_offset;

  modport source(output valid, second, minute, hour, day_of_month, month, weekday,
                 year_offset, input ready);
  modport sink(input valid, second, minute, hour, day_of_month, month, weekday,
               year_offset, output ready);
endinterface

interface ctm_match_if;
  logic valid;
  logic ready;
  logic matched;

  modport source(output valid, matched, input ready);
  modport sink(input valid, matched, output ready);
endinterface

`default_nettype wire

FILE: hdl/cron_time_match_unit.sv
`default_nettype none

// Cron time match unit. Each beat on stamp carries one broken-down time
// (second, minute, hour, day of month from 1, month from 0, weekday from
// Sunday, years since 1970) and yields exactly one beat on result whose
// matched bit says whether that time hits the programmed schedule. Seconds,
// minutes, hours, months and years are plain bit-mask tests; a year offset
// at or past YEAR_SLOTS never matches. The day-of-month test passes on its
// mask bit or on any of RULE_SLOTS day rules (nth-last day, nearest weekday,
// weekday within the last seven days); the weekday test passes on its mask
// bit or on any weekday rule (last given weekday, nth given weekday). Month
// length uses the Gregorian leap rule. Registers are written through
// cfg_we/cfg_index/cfg_data (index 0 second mask .. 7 special rules) and
// must only be written while no beat is in flight. Throughput is one beat
// per clock while results are taken; the beat is held in the input
// register, and the whole calendar check runs as a single combinational
// step into the result register. The stages move together whenever the
// result register is empty or being taken, so a stalled consumer stalls
// the input after one held beat.
module cron_time_match_unit #(
  parameter int YEAR_SLOTS = ctm_pkg::YEAR_SLOTS_DEF,
  parameter int RULE_SLOTS = ctm_pkg::RULE_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ctm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ctm_pkg::CFG_DATA_W-1:0]  cfg_data,
  ctm_time_if.sink                             stamp,
  ctm_match_if.source                          result
);

  localparam int YIDX_W = (YEAR_SLOTS > 1) ? $clog2(YEAR_SLOTS) : 1;
  localparam logic [8:0] YEAR_LIM = 9'(YEAR_SLOTS);

  // Configuration registers
  logic [59:0]           second_mask;
  logic [59:0]           minute_mask;
  logic [23:0]           hour_mask;
  logic [31:0]           mday_mask;
  logic [11:0]           month_mask;
  logic [6:0]            wday_mask;
  logic [YEAR_SLOTS-1:0] year_mask;
  logic [63:0]           special_rules;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_mask   <= '0;
      minute_mask   <= '0;
      hour_mask     <= '0;
      mday_mask     <= '0;
      month_mask    <= '0;
      wday_mask     <= '0;
      year_mask     <= '0;
      special_rules <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ctm_pkg::REG_SECOND_MASK:   second_mask   <= cfg_data[59:0];
        ctm_pkg::REG_MINUTE_MASK:   minute_mask   <= cfg_data[59:0];
        ctm_pkg::REG_HOUR_MASK:     hour_mask     <= cfg_data[23:0];
        ctm_pkg::REG_MDAY_MASK:     mday_mask     <= cfg_data[31:0];
        ctm_pkg::REG_MONTH_MASK:    month_mask    <= cfg_data[11:0];
        ctm_pkg::REG_WDAY_MASK:     wday_mask     <= cfg_data[6:0];
        ctm_pkg::REG_YEAR_MASK:     year_mask     <= cfg_data[YEAR_SLOTS-1:0];
        ctm_pkg::REG_SPECIAL_RULES: special_rules <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: both stages advance together
  logic advance;
  logic s1_valid;

  assign advance     = !result.valid || result.ready;
  assign stamp.ready = !s1_valid || advance;

  // Input register
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [4:0] day_of_month;
  logic [3:0] month;
  logic [2:0] weekday;
  logic [7:0] year_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stamp.valid && stamp.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stamp.valid && stamp.ready) begin
      second       <= stamp.second;
      minute       <= stamp.minute;
      hour         <= stamp.hour;
      day_of_month <= stamp.day_of_month;
      month        <= stamp.month;
      weekday      <= stamp.weekday;
      year_offset  <= stamp.year_offset;
    end
  end

  // Date context shared by the rule slots
  ctm_pkg::ctm_ctx_t ctx;

  assign ctx.mday = day_of_month;
  assign ctx.wd   = (weekday == ctm_pkg::WDAY_ALIAS7) ? ctm_pkg::SUNDAY : weekday;
  assign ctx.dim  = ctm_pkg::month_len(month, ctm_pkg::is_leap(year_offset));

  ctm_pkg::ctm_hit_t hits [RULE_SLOTS];

  for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_slot
    ctm_rule_slot u_slot (
      .day_slot  (special_rules[8*i +: 8]),
      .wday_slot (special_rules[32 + 8*i +: 8]),
      .ctx       (ctx),
      .hit       (hits[i])
    );
  end

  logic any_day_rule;
  logic any_wday_rule;

  always_comb begin
    any_day_rule  = 1'b0;
    any_wday_rule = 1'b0;
    for (int i = 0; i < RULE_SLOTS; i++) begin
      any_day_rule  = any_day_rule  | hits[i].day_hit;
      any_wday_rule = any_wday_rule | hits[i].wday_hit;
    end
  end

  // Field tests; an out-of-range value fails its mask (day of month is not range-checked)
  logic sec_ok, min_ok, hour_ok, mday_ok, month_ok, wday_ok, year_ok;
  logic match_next;

  assign sec_ok   = (second < 6'd60) && second_mask[second];
  assign min_ok   = (minute < 6'd60) && minute_mask[minute];
  assign hour_ok  = (hour < 5'd24) && hour_mask[hour];
  assign mday_ok  = mday_mask[day_of_month] || any_day_rule;
  assign month_ok = (month < 4'd12) && month_mask[month];
  assign wday_ok  = ((weekday != ctm_pkg::WDAY_ALIAS7) && wday_mask[weekday])
                    || any_wday_rule;
  assign year_ok  = ({1'b0, year_offset} < YEAR_LIM)
                    && year_mask[year_offset[YIDX_W-1:0]];

  assign match_next = sec_ok && min_ok && hour_ok && mday_ok && month_ok
                      && wday_ok && year_ok;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.matched <= match_next;
    end
  end

  // An accepted beat always lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    stamp.valid && stamp.ready |=> s1_valid)
    else $error("accepted beat not held in input register");

  // A stalled beat in the input register is not dropped
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("stalled beat lost");

  // A beat moving forward becomes a valid result
  a_moves_out: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> result.valid)
    else $error("beat did not reach result register");

  // With an empty year mask nothing can match
  a_year_gate: assert property (@(posedge clk) disable iff (rst)
    advance && (year_mask == '0) |=> !result.matched)
    else $error("match with empty year mask");

endmodule

`default_nettype wire

FILE: hdl/ctm_rule_slot.sv
`default_nettype none

// One day-of-month slot and one weekday slot, evaluated against the
// current date context.
module ctm_rule_slot (
  input  wire logic [7:0]       day_slot,
  input  wire logic [7:0]       wday_slot,
  input  wire ctm_pkg::ctm_ctx_t ctx,
  output ctm_pkg::ctm_hit_t      hit
);

  logic [1:0] day_kind;
  logic [4:0] arg;
  logic [1:0] wday_kind;
  logic [2:0] target;
  logic [2:0] nth;
  logic       in_month;
  logic [2:0] arg_wd;
  logic [5:0] shifted;
  logic [2:0] week_idx;
  logic       day_hit;
  logic       wday_hit;

  assign day_kind  = day_slot[1:0];
  assign arg       = day_slot[6:2];
  assign wday_kind = wday_slot[1:0];
  assign target    = (wday_slot[4:2] == ctm_pkg::WDAY_ALIAS7) ? ctm_pkg::SUNDAY
                                                               : wday_slot[4:2];
  assign nth       = wday_slot[7:5];

  assign in_month = (ctx.mday != 5'd0) && (ctx.mday <= ctx.dim);
  assign arg_wd   = ctm_pkg::weekday_of(ctx.wd, ctx.mday, arg);

  // nearest weekday to arg
  always_comb begin
    if (arg_wd == ctm_pkg::SATURDAY) begin
      shifted = (arg > 5'd1) ? 6'(arg) - 6'd1 : 6'(arg) + 6'd2;
    end else if (arg_wd == ctm_pkg::SUNDAY) begin
      shifted = (arg < ctx.dim) ? 6'(arg) + 6'd1 : 6'(arg) - 6'd2;
    end else begin
      shifted = 6'(arg);
    end
  end

  // (mday-1)/7 for mday 1..31
  always_comb begin
    if (ctx.mday > 5'd28) begin
      week_idx = 3'd4;
    end else if (ctx.mday > 5'd21) begin
      week_idx = 3'd3;
    end else if (ctx.mday > 5'd14) begin
      week_idx = 3'd2;
    end else if (ctx.mday > 5'd7) begin
      week_idx = 3'd1;
    end else begin
      week_idx = 3'd0;
    end
  end

  always_comb begin
    case (day_kind)
      ctm_pkg::DAY_KIND_NTH_LAST:
        day_hit = in_month && (6'(ctx.mday) + 6'(arg) == 6'(ctx.dim) + 6'd1);
      ctm_pkg::DAY_KIND_NEAREST:
        day_hit = in_month && (arg != 5'd0) && (arg <= ctx.dim)
                  && (shifted == 6'(ctx.mday));
      ctm_pkg::DAY_KIND_LAST_WEEK:
        day_hit = in_month && (6'(ctx.dim) < 6'(ctx.mday) + 6'd7)
                  && (ctx.wd inside {[ctm_pkg::MONDAY:ctm_pkg::FRIDAY]});
      default:
        day_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (wday_kind)
      ctm_pkg::WDAY_KIND_LAST:
        wday_hit = in_month && (ctx.wd == target)
                   && (6'(ctx.mday) + 6'd7 > 6'(ctx.dim));
      ctm_pkg::WDAY_KIND_NTH:
        wday_hit = in_month && (ctx.wd == target) && (nth != 3'd0)
                   && (week_idx == nth - 3'd1);
      default:
        wday_hit = 1'b0;
    endcase
  end

  assign hit = '{day_hit: day_hit, wday_hit: wday_hit};

endmodule

`default_nettype wire
